### src/thermal_head_line_sequencer_unit_assert.svh
// Assertion macros for the thermal head line sequencer RTL (included by thlseq_seq).
// Needs clk and arst_n in the scope of each use; no other dependencies.
`ifndef THERMAL_HEAD_LINE_SEQUENCER_UNIT_ASSERT_SVH
`define THERMAL_HEAD_LINE_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define THLS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("thlseq assertion failed");
// next-cycle implication
`define THLS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("thlseq assertion failed");
`else
`define THLS_ASSERT_IMP(lbl, ante, cons)
`define THLS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/thlseq_pkg.sv
// Package for the thermal head line sequencer: codes, constants and the
// structs passed between its modules. No dependencies.
package thlseq_pkg;

	localparam int LINE_BYTES = 48;
	localparam int POS_W      = 6;

	localparam logic [15:0] CLOCK_DWELL = 16'd2;
	localparam logic [15:0] LATCH_DWELL = 16'd2;
	localparam logic [15:0] STROBE_RST  = 16'd3000;
	localparam logic [15:0] PHASE_RST   = 16'd700;
	localparam logic [3:0]  MAX_FEED    = 4'd8;

	localparam logic [1:0] CFG_INVERT = 2'd0;
	localparam logic [1:0] CFG_STROBE = 2'd1;
	localparam logic [1:0] CFG_PHASE  = 2'd2;

	typedef enum logic [1:0] {
		OP_LINE = 2'd0,
		OP_FEED = 2'd1,
		OP_OFF  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_SHIFT  = 3'd0,
		EV_LATCH  = 3'd1,
		EV_STROBE = 3'd2,
		EV_PHASE  = 3'd3,
		EV_OFF    = 3'd4
	} event_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_LATCH,
		ST_STROBE,
		ST_PHASE,
		ST_OFF
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] bits;   // already inverted if enabled
		logic [3:0] steps;  // already saturated
	} cmd_t;

	typedef struct packed {
		logic load;
		logic shift;
	} shf_ctrl_t;

	typedef struct packed {
		logic msb;
		logic last_bit;
	} shf_stat_t;

endpackage

### src/thlseq_shifter.sv
// Bit-serial line data shifter: loads one byte, shifts it out MSB first.
// Depends on thlseq_pkg.
module thlseq_shifter import thlseq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  shf_ctrl_t  ctrl,
	input  logic [7:0] load_byte,
	output shf_stat_t  stat
);

	logic [7:0] shreg_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			shreg_q <= load_byte;
		end else if (ctrl.shift) begin
			shreg_q <= {shreg_q[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (ctrl.load) begin
			cnt_q <= 3'd7;
		end else if (ctrl.shift) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	assign stat.msb      = shreg_q[7];
	assign stat.last_bit = (cnt_q == 3'd0);

endmodule

### src/thlseq_seq.sv
// Event sequencer: line position, phase half, phase/step counters and the
// result register. Depends on thlseq_pkg, thlseq_shifter and the assert header.
`include "thermal_head_line_sequencer_unit_assert.svh"
module thlseq_seq import thlseq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_ready,
	input  logic [15:0] strobe_dwell,
	input  logic [15:0] phase_dwell,
	output logic        ev_valid,
	input  logic        ev_ready,
	output event_kind_t ev_kind,
	output logic        ev_level,
	output logic [2:0]  ev_phase,
	output logic [15:0] ev_dwell,
	output logic        ev_last
);

	state_t            state_q, state_d;
	logic              line_q, line_d;
	logic              half_q, half_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [2:0]        pcnt_q, pcnt_d;
	logic [3:0]        scnt_q, scnt_d;
	logic              out_v_q;
	event_kind_t       kind_q;
	logic              level_q;
	logic [2:0]        phase_q;
	logic [15:0]       dwell_q;
	logic              last_q;

	logic              adv, accept, line_done, emit;
	event_kind_t       e_kind;
	logic              e_level, e_last;
	logic [2:0]        e_phase;
	logic [15:0]       e_dwell;
	shf_ctrl_t         shf_ctrl;
	shf_stat_t         shf_stat;

	thlseq_shifter u_shifter (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (shf_ctrl),
		.load_byte (cmd.bits),
		.stat      (shf_stat)
	);

	assign adv       = !out_v_q || ev_ready;
	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign line_done = ({1'b0, pos_q} + 7'd1) >= 7'(LINE_BYTES);

	always_comb begin
		state_d  = state_q;
		line_d   = line_q;
		half_d   = half_q;
		pos_d    = pos_q;
		pcnt_d   = pcnt_q;
		scnt_d   = scnt_q;
		emit     = 1'b0;
		e_kind   = EV_SHIFT;
		e_level  = 1'b0;
		e_phase  = 3'd0;
		e_dwell  = 16'd0;
		e_last   = 1'b0;
		shf_ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.op)
						OP_LINE: begin
							shf_ctrl.load = 1'b1;
							line_d        = line_done;
							pos_d         = line_done ? '0 : pos_q + POS_W'(1);
							state_d       = ST_SHIFT;
						end
						OP_FEED: begin
							if (cmd.steps != 4'd0) begin
								scnt_d  = cmd.steps;
								pcnt_d  = 3'd0;
								line_d  = 1'b0;
								state_d = ST_PHASE;
							end
						end
						OP_OFF:  state_d = ST_OFF;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SHIFT: begin
				if (adv) begin
					emit           = 1'b1;
					e_kind         = EV_SHIFT;
					e_level        = shf_stat.msb;
					e_dwell        = CLOCK_DWELL;
					e_last         = shf_stat.last_bit && !line_q;
					shf_ctrl.shift = 1'b1;
					if (shf_stat.last_bit) begin
						state_d = line_q ? ST_LATCH : ST_IDLE;
					end
				end
			end
			ST_LATCH: begin
				if (adv) begin
					emit    = 1'b1;
					e_kind  = EV_LATCH;
					e_level = 1'b1;
					e_dwell = LATCH_DWELL;
					state_d = ST_STROBE;
				end
			end
			ST_STROBE: begin
				if (adv) begin
					emit    = 1'b1;
					e_kind  = EV_STROBE;
					e_level = 1'b1;
					e_dwell = strobe_dwell;
					pcnt_d  = 3'd0;
					state_d = ST_PHASE;
				end
			end
			ST_PHASE: begin
				if (adv) begin
					emit    = 1'b1;
					e_kind  = EV_PHASE;
					// upper counter bit selects the other half within a feed step
					e_phase = {half_q ^ pcnt_q[2], pcnt_q[1:0]};
					e_dwell = phase_dwell;
					pcnt_d  = pcnt_q + 3'd1;
					if (line_q) begin
						e_last = (pcnt_q == 3'd3);
						if (e_last) begin
							half_d  = ~half_q;
							state_d = ST_IDLE;
						end
					end else if (pcnt_q == 3'd7) begin
						scnt_d = scnt_q - 4'd1;
						e_last = (scnt_q == 4'd1);
						if (e_last) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_OFF: begin
				if (adv) begin
					emit    = 1'b1;
					e_kind  = EV_OFF;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_q  <= 1'b0;
			half_q  <= 1'b0;
			pos_q   <= '0;
			pcnt_q  <= 3'd0;
			scnt_q  <= 4'd0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			line_q  <= line_d;
			half_q  <= half_d;
			pos_q   <= pos_d;
			pcnt_q  <= pcnt_d;
			scnt_q  <= scnt_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (ev_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= e_kind;
			level_q <= e_level;
			phase_q <= e_phase;
			dwell_q <= e_dwell;
			last_q  <= e_last;
		end
	end

	assign ev_valid = out_v_q;
	assign ev_kind  = kind_q;
	assign ev_level = level_q;
	assign ev_phase = phase_q;
	assign ev_dwell = dwell_q;
	assign ev_last  = last_q;

	`THLS_ASSERT_IMP(a_pos_in_line, 1'b1, pos_q < POS_W'(LINE_BYTES))
	`THLS_ASSERT_IMP(a_line_phase_low, (state_q == ST_PHASE) && line_q, !pcnt_q[2])
	`THLS_ASSERT_IMP(a_feed_steps_left, (state_q == ST_PHASE) && !line_q, scnt_q != 4'd0)
	`THLS_ASSERT_NXT(a_half_flips, adv && (state_q == ST_PHASE) && line_q && (pcnt_q == 3'd3), half_q != $past(half_q))

endmodule

### src/thermal_head_line_sequencer_unit.sv
// Top level of the thermal head line sequencer: stream ports, configuration
// registers and input decode. Depends on thlseq_pkg and thlseq_seq.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tuser op, tdata byte + feed steps
//  m_*       out        m_tvalid/m_tready  tuser kind, tdata level/phase/dwell
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
// One event per cycle while the output register is free. A line byte gives a
// shift event per bit, then latch, strobe and phase events if it ends a line;
// a feed gives phase events per step. A new item is taken once the sequencer
// is back in idle, as its last event is registered. A held event and m_tready low stall it.
// Reset restores the register defaults, line position 0 and phase half 0.
module thermal_head_line_sequencer_unit import thlseq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [11:8] feed_steps
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] data_level, [3:1] phase_index, [19:4] dwell_us
	output logic [2:0]  m_tuser,   // [2:0] event_kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        invert_q;
	logic [15:0] strobe_q;
	logic [15:0] phase_q;
	cmd_t        cmd;
	logic [7:0]  in_byte;
	logic [3:0]  in_steps;
	event_kind_t ev_kind;
	logic        ev_level;
	logic [2:0]  ev_phase;
	logic [15:0] ev_dwell;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b1;
			strobe_q <= STROBE_RST;
			phase_q  <= PHASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INVERT: invert_q <= cfg_data[0];
				CFG_STROBE: strobe_q <= cfg_data;
				CFG_PHASE:  phase_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign in_byte   = s_tdata[7:0];
	assign in_steps  = s_tdata[11:8];
	assign cmd.op    = op_t'(s_tuser);
	assign cmd.bits  = invert_q ? ~in_byte : in_byte;
	assign cmd.steps = (in_steps > MAX_FEED) ? MAX_FEED : in_steps;

	thlseq_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (s_tvalid),
		.cmd          (cmd),
		.cmd_ready    (s_tready),
		.strobe_dwell (strobe_q),
		.phase_dwell  (phase_q),
		.ev_valid     (m_tvalid),
		.ev_ready     (m_tready),
		.ev_kind      (ev_kind),
		.ev_level     (ev_level),
		.ev_phase     (ev_phase),
		.ev_dwell     (ev_dwell),
		.ev_last      (m_tlast)
	);

	assign m_tuser = ev_kind;
	assign m_tdata = {4'b0000, ev_dwell, ev_phase, ev_level};

endmodule
